### hw/rtl/binary_to_bcd_converter_macros.svh
// Assertion macros used by the converter controller.
`ifndef BINARY_TO_BCD_CONVERTER_MACROS_SVH
`define BINARY_TO_BCD_CONVERTER_MACROS_SVH
`ifndef SYNTHESIS
`define B2BCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b2bcd assertion failed");
`define B2BCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b2bcd assertion failed");
`else
`define B2BCD_ASSERT_SAME(label, ante, cons)
`define B2BCD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hw/rtl/b2bcd_pkg.sv
// Shared constants and controller-to-datapath types of the BCD converter.
package b2bcd_pkg;

    localparam int VALUE_W   = 32;
    localparam int BCD_W     = 40;
    localparam int OUT_DIGITS = 10;
    localparam int COUNT_W   = 4;
    localparam int BIT_CNT_W = 5;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic last_bit;
    } t_dp_status;

endpackage

### hw/rtl/b2bcd_datapath.sv
// Shift-and-add-3 datapath with the digit registers and the result register.
module b2bcd_datapath #(
    parameter int DIGITS = 10
) (
    input  logic                              i_clk,
    input  b2bcd_pkg::t_dp_cmd                i_cmd,
    output b2bcd_pkg::t_dp_status             o_status,
    input  logic signed [b2bcd_pkg::VALUE_W-1:0] i_value,
    output logic [b2bcd_pkg::BCD_W-1:0]       o_bcd_digits,
    output logic [b2bcd_pkg::COUNT_W-1:0]     o_digit_count,
    output logic                              o_invalid
);

    localparam int CNT_W = $clog2(DIGITS + 1);
    localparam int EXT_DIGITS = (DIGITS > b2bcd_pkg::OUT_DIGITS) ? DIGITS
                                                                 : b2bcd_pkg::OUT_DIGITS;

    logic [b2bcd_pkg::VALUE_W-1:0]   r_bin;
    logic [DIGITS-1:0][3:0]          r_dig;
    logic [DIGITS-1:0][3:0]          n_dig;
    logic [DIGITS-1:0][3:0]          w_adj;
    logic                            r_ovf;
    logic                            r_neg;
    logic [b2bcd_pkg::BIT_CNT_W-1:0] r_bit_cnt;
    logic                            w_carry;
    logic [CNT_W-1:0]                w_cnt;
    logic [EXT_DIGITS*4-1:0]         w_ext;
    logic                            w_bad;

    logic [b2bcd_pkg::BCD_W-1:0]     r_bcd;
    logic [b2bcd_pkg::COUNT_W-1:0]   r_count;
    logic                            r_invalid;

    always_comb begin
        w_carry = r_bin[b2bcd_pkg::VALUE_W-1];
        for (int d = 0; d < DIGITS; d++) begin
            w_adj[d] = (r_dig[d] >= 4'd5) ? r_dig[d] + 4'd3 : r_dig[d];
            n_dig[d] = {w_adj[d][2:0], w_carry};
            w_carry  = w_adj[d][3];
        end
    end

    always_comb begin
        w_cnt = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (r_dig[d] != 4'd0) begin
                w_cnt = CNT_W'(d + 1);
            end
        end
        if (w_cnt == '0) begin
            w_cnt = CNT_W'(1);
        end
    end

    assign w_ext = (EXT_DIGITS*4)'(r_dig);
    assign w_bad = r_neg | r_ovf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin     <= i_value;
            r_dig     <= '0;
            r_ovf     <= 1'b0;
            r_neg     <= i_value[b2bcd_pkg::VALUE_W-1];
            r_bit_cnt <= '0;
        end else if (i_cmd.step) begin
            r_bin     <= {r_bin[b2bcd_pkg::VALUE_W-2:0], 1'b0};
            r_dig     <= n_dig;
            r_ovf     <= r_ovf | w_carry;
            r_bit_cnt <= r_bit_cnt + 1'b1;
        end
        if (i_cmd.capture) begin
            r_bcd     <= w_bad ? '0 : w_ext[b2bcd_pkg::BCD_W-1:0];
            r_count   <= w_bad ? '0 : b2bcd_pkg::COUNT_W'(w_cnt);
            r_invalid <= w_bad;
        end
    end

    assign o_status.last_bit = (r_bit_cnt == {b2bcd_pkg::BIT_CNT_W{1'b1}});
    assign o_bcd_digits      = r_bcd;
    assign o_digit_count     = r_count;
    assign o_invalid         = r_invalid;

endmodule

### hw/rtl/b2bcd_ctrl.sv
// Controller state machine and output valid register of the BCD converter.
`include "binary_to_bcd_converter_macros.svh"

module b2bcd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    input  b2bcd_pkg::t_dp_status i_status,
    output b2bcd_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_status.last_bit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    `B2BCD_ASSERT_NEXT(a_load_starts_conv, o_cmd.load, r_state == S_CONV)
    `B2BCD_ASSERT_SAME(a_no_overwrite, o_cmd.capture, !r_out_valid || !i_stall)
    `B2BCD_ASSERT_NEXT(a_conv_ends, (r_state == S_CONV) && i_status.last_bit, r_state == S_DONE)
    `B2BCD_ASSERT_SAME(a_valid_from_done, $rose(r_out_valid), $past(r_state == S_DONE))

endmodule

### hw/rtl/binary_to_bcd_converter.sv
// Top level of the binary to packed BCD converter.
// Input channel: i_valid, o_stall and i_value. A beat is taken when i_valid is high and
// o_stall is low; o_stall is low only while the converter is idle.
// Output channel: o_valid, i_stall and the fields o_bcd_digits, o_digit_count, o_invalid.
// A beat leaves when o_valid is high and i_stall is low.
// Each item is loaded, passes through 32 shift-and-add-3 steps (one per input bit
// through the single digit adjust stage), and is then written to the result register.
// The next input beat is taken the cycle after the result is written, so a result may
// wait in the output register while the following item converts.
// A negative input, or one that needs more than DIGITS digits, gives o_invalid high with
// zero digits and a count of zero.
// While the receiver stalls, the finished result stays in the output register and a
// second finished item waits inside the converter, holding o_stall high.
// Reset is synchronous and active low; it empties the converter and drops o_valid.
module binary_to_bcd_converter #(
    parameter int DIGITS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [b2bcd_pkg::VALUE_W-1:0] i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [b2bcd_pkg::BCD_W-1:0]          o_bcd_digits,
    output logic [b2bcd_pkg::COUNT_W-1:0]        o_digit_count,
    output logic                                 o_invalid
);

    b2bcd_pkg::t_dp_cmd    w_cmd;
    b2bcd_pkg::t_dp_status w_status;

    b2bcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    b2bcd_datapath #(
        .DIGITS (DIGITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_value       (i_value),
        .o_bcd_digits  (o_bcd_digits),
        .o_digit_count (o_digit_count),
        .o_invalid     (o_invalid)
    );

endmodule

### tb/binary_to_bcd_converter_checker.sv
// Checker that predicts the packed BCD result of every input beat and compares it at the output.
module binary_to_bcd_converter_checker #(
    parameter int DIGITS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [b2bcd_pkg::VALUE_W-1:0] i_value,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic [b2bcd_pkg::BCD_W-1:0]          i_bcd_digits,
    input  logic [b2bcd_pkg::COUNT_W-1:0]        i_digit_count,
    input  logic                                 i_invalid,
    output int                                   o_mismatches,
    output int                                   o_outstanding
);

    typedef struct packed {
        logic [b2bcd_pkg::BCD_W-1:0]   digits;
        logic [b2bcd_pkg::COUNT_W-1:0] count;
        logic                          invalid;
    } t_bcd_result;

    t_bcd_result awaited_results[$];
    int mismatch_count = 0;

    function automatic t_bcd_result decimal_of(input logic signed [b2bcd_pkg::VALUE_W-1:0] value);
        t_bcd_result result;
        logic [b2bcd_pkg::BCD_W-1:0] packed_digits;
        logic [b2bcd_pkg::VALUE_W-1:0] rest;
        int places;
        result = '0;
        if (value < 0) begin
            result.invalid = 1'b1;
            return result;
        end
        packed_digits = '0;
        rest = value;
        places = 0;
        do begin
            packed_digits[4*places +: 4] = 4'(rest % 10);
            rest = rest / 10;
            places++;
        end while (rest != 0);
        // A value wider than the digit positions is rejected like a negative one.
        if (places > DIGITS) begin
            result.invalid = 1'b1;
            return result;
        end
        result.digits = packed_digits;
        result.count = 4'(places);
        return result;
    endfunction

    always @(posedge i_clk) begin
        t_bcd_result want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected beat: digits %h count %0d invalid %b",
                                 i_bcd_digits, i_digit_count, i_invalid);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_bcd_digits !== want.digits || i_digit_count !== want.count ||
                        i_invalid !== want.invalid) begin
                        if (mismatch_count < 10)
                            $display("mismatch: digits %h/%h count %0d/%0d invalid %b/%b",
                                     i_bcd_digits, want.digits, i_digit_count, want.count,
                                     i_invalid, want.invalid);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(decimal_of(i_value));
        end
        o_mismatches <= mismatch_count;
        o_outstanding <= awaited_results.size();
    end

endmodule

### tb/binary_to_bcd_converter_tb.sv
// Top of the converter testbench: clock, reset, stimulus, receiver and the final verdict.
module binary_to_bcd_converter_tb;

    localparam int DIGITS = 10;
    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES = 40;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic signed [b2bcd_pkg::VALUE_W-1:0] i_value;
    logic                                 o_valid;
    logic                                 i_stall;
    logic [b2bcd_pkg::BCD_W-1:0]          o_bcd_digits;
    logic [b2bcd_pkg::COUNT_W-1:0]        o_digit_count;
    logic                                 o_invalid;
    int                                   mismatches;
    int                                   outstanding;
    logic                                 steady_send;

    int corner_values [22] = '{
        0, 1, 5, 9, 10, 99, 100, 999, 1000, 12345678, 99999999, 100000000,
        999999999, 1000000000, 1234567890, 2147483647, 1431655765, 715827882,
        -1, -10, -2147483647, -2147483647 - 1
    };

    binary_to_bcd_converter #(
        .DIGITS(DIGITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_bcd_digits(o_bcd_digits),
        .o_digit_count(o_digit_count),
        .o_invalid(o_invalid)
    );

    binary_to_bcd_converter_checker #(
        .DIGITS(DIGITS)
    ) result_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_valid),
        .i_in_stall(o_stall),
        .i_value(i_value),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_bcd_digits(o_bcd_digits),
        .i_digit_count(o_digit_count),
        .i_invalid(o_invalid),
        .o_mismatches(mismatches),
        .o_outstanding(outstanding)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic offer_value(input logic signed [b2bcd_pkg::VALUE_W-1:0] value);
        int gap;
        gap = steady_send ? 0 : $urandom_range(7);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        logic signed [b2bcd_pkg::VALUE_W-1:0] value;
        int kind;
        int places;
        longint lo;
        longint hi;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        steady_send = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (corner_values[n])
            offer_value(corner_values[n]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_send = (n >= 200 && n < 280);
            kind = $urandom_range(99);
            if (kind < 25) begin
                value = $urandom;
            end else if (kind < 60) begin
                places = $urandom_range(10, 1);
                lo = 1;
                repeat (places - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (places == 1)
                    lo = 0;
                if (hi > 64'h7fff_ffff)
                    hi = 64'h7fff_ffff;
                value = $urandom_range(32'(hi), 32'(lo));
            end else if (kind < 75) begin
                value = $urandom | 32'h8000_0000;
            end else if (kind < 85) begin
                value = $urandom_range(20);
            end else begin
                value = 32'h1 << $urandom_range(31);
            end
            offer_value(value);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // The receiver stalls a random number of cycles before most beats, takes a run of beats
    // without stalling, and once holds off long enough for the converter to fill up and stall its input.
    initial begin
        int wait_cycles;
        int taken;
        i_stall = 1'b0;
        taken = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken == 100)
                wait_cycles = HOLD_OFF_CYCLES;
            else if (taken >= 320 && taken < 400)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(7);
            repeat (wait_cycles) begin
                i_stall <= 1'b1;
                @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    initial begin
        #(12 * 200000);
        $display("simulation failed");
        $finish;
    end

endmodule
